[rtl/core/mfr_pkg.sv]
// shared types and constants of the marker frame receiver
package mfr_pkg;

	// frame marker bytes
	localparam logic [7:0] MARK_OPEN  = 8'hFF;
	localparam logic [7:0] MARK_CLOSE = 8'hFE;

	// request codes
	typedef enum logic [1:0] {
		REQ_BYTE    = 2'd0,
		REQ_READ    = 2'd1,
		REQ_RELEASE = 2'd2
	} req_t;

	// link mode
	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_HALF  = 3'd1,
		MODE_IN    = 3'd2,
		MODE_READY = 3'd3,
		MODE_ENDED = 3'd4
	} mode_t;

	// state after one beat, as seen by the result path
	typedef struct packed {
		logic       done;
		logic [7:0] count;
		mode_t      mode;
	} upd_t;

endpackage

[rtl/core/mfr_ram.sv]
// generic simple dual-port ram with registered read
module mfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/mfr_ctrl.sv]
// link mode state machine and wrapping write counter
module mfr_ctrl import mfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  req_t       req,
	input  logic [7:0] rx_byte,
	output upd_t       upd,
	output logic [7:0] wr_addr
);

	mode_t      mode_q;
	logic [7:0] count_q;
	mode_t      nxt_mode;
	logic [7:0] base_count;
	logic [7:0] nxt_count;
	logic       done;

	// state registers, updated on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			count_q <= 8'd0;
		end else if (accept) begin
			mode_q  <= nxt_mode;
			count_q <= nxt_count;
		end
	end

	// next mode, counter and done pulse
	always_comb begin
		nxt_mode   = mode_q;
		base_count = count_q;
		nxt_count  = count_q;
		done       = 1'b0;
		unique case (req)
			REQ_BYTE: begin
				if (rx_byte == MARK_OPEN) begin
					unique case (mode_q)
						MODE_IDLE: begin
							base_count = 8'd0;
							nxt_mode   = MODE_HALF;
						end
						MODE_HALF: begin
							nxt_mode = MODE_IN;
						end
						default: begin
							nxt_mode = mode_q;
						end
					endcase
				end else if (rx_byte == MARK_CLOSE) begin
					unique case (mode_q)
						MODE_IN: begin
							nxt_mode = MODE_READY;
						end
						MODE_READY: begin
							nxt_mode = MODE_ENDED;
							done     = 1'b1;
						end
						default: begin
							nxt_mode = MODE_IN;
						end
					endcase
				end else begin
					nxt_mode = MODE_IN;
				end
				nxt_count = base_count + 8'd1;
			end
			REQ_RELEASE: begin
				nxt_mode = MODE_IDLE;
			end
			default: begin
				nxt_mode = mode_q;
			end
		endcase
	end

	assign upd.done  = done;
	assign upd.count = nxt_count;
	assign upd.mode  = nxt_mode;
	assign wr_addr   = base_count;

`ifndef SYNTH
	// release always lands in idle
	a_release_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_RELEASE |=> mode_q == MODE_IDLE)
		else $error("release did not return mode to idle");

	// opening marker from idle restarts the counter
	a_open_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_BYTE && rx_byte == MARK_OPEN && mode_q == MODE_IDLE
		|=> count_q == 8'd1 && mode_q == MODE_HALF)
		else $error("opening marker did not restart the frame");

	// done pulses only out of ready end
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> mode_q == MODE_READY && nxt_mode == MODE_ENDED)
		else $error("frame done outside of ready end");
`endif

endmodule

[rtl/core/marker_frame_receiver.sv]
// marker frame receiver top level: result stage, buffer ram and output register
// Takes one request beat per clock unless stalled: a received byte, a buffer
// read or a frame release. Frames open with FF FF and close with FE FE; every
// received byte, markers included, is written to the frame buffer at the 8-bit
// write counter when it is below BUF_DEPTH, and the counter then wraps modulo
// 256; the opening FF from idle restarts the counter at 0. Each beat gives one
// result beat, and a new beat can be taken every clock unless stalled: the mode
// and counter update as each beat is accepted, and a read is served by the
// registered read port of the buffer ram. A result stage plus an output
// register let one more beat be taken while a result waits under stall. The
// buffer has no reset and no clearing pass; reading an entry that was never
// written returns an arbitrary byte, and reads at or above BUF_DEPTH return 0.
module marker_frame_receiver import mfr_pkg::*; #(
	parameter int BUF_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_index,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic       frame_done,
	output logic [7:0] byte_count,
	output logic [2:0] link_mode,
	output logic [7:0] read_data
);

	localparam int AW = $clog2(BUF_DEPTH);

	logic       accept;
	req_t       req;
	upd_t       upd;
	logic [7:0] wr_addr;
	logic       wr_hit;
	logic       rd_hit;
	logic       ram_we;
	logic       ram_re;
	logic [7:0] ram_q;

	logic       valid_s1;
	upd_t       upd_s1;
	logic       rd_hit_s1;
	logic       go_s1;

	logic       valid_s2;
	upd_t       upd_s2;
	logic [7:0] rdata_s2;

	assign req    = req_t'(req_type);
	assign go_s1  = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !go_s1;
	assign accept = req_valid && !req_stall;

	// mode and counter
	mfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req     (req),
		.rx_byte (rx_byte),
		.upd     (upd),
		.wr_addr (wr_addr)
	);

	// buffer range checks
	assign wr_hit = {1'b0, wr_addr} < 9'(BUF_DEPTH);
	assign rd_hit = {1'b0, read_index} < 9'(BUF_DEPTH);
	assign ram_we = accept && req == REQ_BYTE && wr_hit;
	assign ram_re = accept && req == REQ_READ;

	// frame buffer
	mfr_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr[AW-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (read_index[AW-1:0]),
		.rdata (ram_q)
	);

	// result stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// result stage and output register payloads, ram data joins at the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			upd_s1    <= upd;
			rd_hit_s1 <= ram_re && rd_hit;
		end
		if (go_s1) begin
			upd_s2   <= upd_s1;
			rdata_s2 <= rd_hit_s1 ? ram_q : 8'd0;
		end
	end

	assign rsp_valid  = valid_s2;
	assign frame_done = upd_s2.done;
	assign byte_count = upd_s2.count;
	assign link_mode  = upd_s2.mode;
	assign read_data  = rdata_s2;

`ifndef SYNTH
	// a result beat with done always reports the ended mode
	a_done_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && upd_s2.done |-> upd_s2.mode == MODE_ENDED)
		else $error("frame done reported outside ended mode");

	// input only stalls when both result slots are full and blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2 && rsp_stall)
		else $error("request stalled with a free result slot");

	// a read beat never reports a done pulse
	a_read_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_READ |=> !upd_s1.done)
		else $error("read beat carried frame done");
`endif

endmodule
